// File: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants, types and fixed-point helpers for the cylindrical
// hydro source term block (signed Q16.16 arithmetic).
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int W         = 32;            // word width of every field
  localparam int FRAC_BITS = 16;            // fraction bits of the fixed-point format
  localparam int SAT_W     = 66;            // headroom for sums of two products
  localparam int QBITS     = 33;            // quotient bits formed by the divider
  localparam int DIV_LAT   = QBITS + 2;     // registers in the divider, entry and output stages included

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_DIR_X    = 2'd2;
  localparam logic [1:0] REG_DIR_Y    = 2'd3;

  localparam logic signed [W-1:0] DIR_Y_RESET = 32'sh0001_0000;

  // axis length square root sequencer
  typedef enum logic [1:0] {
    SQ_LOAD,
    SQ_RUN,
    SQ_IDLE
  } sq_state_t;

  // divider request: unsigned numerator magnitude, its sign, divisor
  typedef struct packed {
    logic [63:0] num_mag;
    logic        num_neg;
    logic [30:0] den;
  } div_in_t;

  localparam logic signed [SAT_W-1:0] SMAX = 66'sd2147483647;
  localparam logic signed [SAT_W-1:0] SMIN = -66'sd2147483648;

  // saturate a wide signed value to one word
  function automatic logic signed [W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [W-1:0] res;
    if (v > SMAX) begin
      res = SMAX[W-1:0];
    end else if (v < SMIN) begin
      res = SMIN[W-1:0];
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  // exact signed product
  function automatic logic signed [63:0] mul(input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // product shifted down by the fraction bits (floor), saturated
  function automatic logic signed [W-1:0] qsh(input logic signed [63:0] p);
    logic signed [SAT_W-1:0] x;
    x = SAT_W'(p);
    return sat32(x >>> FRAC_BITS);
  endfunction

  // magnitude of a word, unsigned
  function automatic logic [W-1:0] abs32(input logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

endpackage

// File: rtl/cht_div.sv
// ----------------------------------------------------------------------------
// cht_div
// Pipelined restoring divider, one quotient bit per stage. Signed numerator
// over a positive divisor, truncated toward zero and saturated to one word;
// a zero divisor gives zero.
// ----------------------------------------------------------------------------
module cht_div (
  input  logic                        clk,
  input  logic                        ce,
  input  cht_pkg::div_in_t            din,
  output logic signed [cht_pkg::W-1:0] quo
);
  import cht_pkg::*;

  localparam logic [QBITS-1:0] CAP = QBITS'(33'h1_0000_0000 >> 1);

  logic [30:0]       rem_q [0:QBITS];
  logic [QBITS-1:0]  low_q [0:QBITS];
  logic [QBITS-1:0]  q_q   [0:QBITS];
  logic [30:0]       den_q [0:QBITS];
  logic              neg_q [0:QBITS];
  logic              ovf_q [0:QBITS];
  logic              dz_q  [0:QBITS];

  // entry stage: high part becomes the starting remainder
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_q[0] <= din.num_mag[63:QBITS];
      low_q[0] <= din.num_mag[QBITS-1:0];
      q_q[0]   <= '0;
      den_q[0] <= din.den;
      neg_q[0] <= din.num_neg;
      ovf_q[0] <= (din.num_mag[63:QBITS] >= din.den);
      dz_q[0]  <= (din.den == 31'd0);
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [31:0] trial;
    logic        take;
    assign trial = {rem_q[k-1], low_q[k-1][QBITS-1]};
    assign take  = (trial >= {1'b0, den_q[k-1]});
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[k] <= take ? 31'(trial - {1'b0, den_q[k-1]}) : trial[30:0];
        low_q[k] <= {low_q[k-1][QBITS-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QBITS-2:0], take};
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        dz_q[k]  <= dz_q[k-1];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (ce) begin
      if (dz_q[QBITS]) begin
        quo <= '0;
      end else if (neg_q[QBITS]) begin
        if (ovf_q[QBITS] || (q_q[QBITS] > CAP)) begin
          quo <= SMIN[W-1:0];
        end else begin
          quo <= W'(-q_q[QBITS]);
        end
      end else begin
        if (ovf_q[QBITS] || (q_q[QBITS] >= CAP)) begin
          quo <= SMAX[W-1:0];
        end else begin
          quo <= q_q[QBITS][W-1:0];
        end
      end
    end
  end

endmodule

// File: rtl/cylindrical_hydro_source_term.sv
// ----------------------------------------------------------------------------
// cylindrical_hydro_source_term
// Per-cell cylindrical geometric source terms (mass, momentum, energy,
// tracer) about a configurable symmetry axis, signed Q16.16.
// ----------------------------------------------------------------------------
// One cell enters per clock and one result leaves per clock once the pipe is
// full, while the result side takes results and no axis length is being
// formed. A result passes three dividers in series (radius and velocities,
// then the flux terms over the radius, then the momentum projection), each forming one
// quotient bit per stage, plus fifteen other register stages. A stall
// on the result side holds the whole pipe. After reset and after each write
// to an axis direction register the axis length is found by a bit-serial
// square root; no item is taken in that time.
// Input tdata carries cell_tag, density, vel_x, vel_y, pressure, spec_energy,
// center_x, center_y, cell_volume, tracer_value, 32 bits each from bit 0 up.
// ----------------------------------------------------------------------------
module cylindrical_hydro_source_term (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_tag, density, vel_x, vel_y, pressure, spec_energy, center_x,
  // center_y, cell_volume, tracer_value
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tag_out, mass_src, mom_src_x, mom_src_y, energy_src, tracer_src
  output logic [191:0] m_axis_tdata,
  // on_axis
  output logic [0:0]   m_axis_tuser
);
  import cht_pkg::*;

  typedef struct packed {
    logic [W-1:0]        tag;
    logic signed [W-1:0] d, vx, vy, p, e, vol, t, rx, ry;
    logic signed [63:0]  pa, pb, pc, pd, pe, pf;
    logic [63:0]         ma, mb, mc;
    logic                na, nb, nc;
    logic                on_axis;
    logic signed [W-1:0] r, vr, vz, dv, ke, h, rmn, zmn, dh, q, vq;
    logic signed [W-1:0] fm, rm, zm, fe, ft, fx, fy;
  } pipe_t;

  // configuration registers
  logic signed [W-1:0] axis_origin_x, axis_origin_y, axis_dir_x, axis_dir_y;
  logic                dir_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_origin_x <= '0;
      axis_origin_y <= '0;
      axis_dir_x    <= '0;
      axis_dir_y    <= DIR_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: axis_origin_x <= cfg_data;
        REG_ORIGIN_Y: axis_origin_y <= cfg_data;
        REG_DIR_X:    axis_dir_x    <= cfg_data;
        REG_DIR_Y:    axis_dir_y    <= cfg_data;
        default:      axis_dir_y    <= axis_dir_y;
      endcase
    end
  end

  assign dir_wr = cfg_we && ((cfg_index == REG_DIR_X) || (cfg_index == REG_DIR_Y));

  // axis length: bit-serial floor square root
  sq_state_t    sq_state, sq_state_next;
  logic [63:0]  sq_a;
  logic [31:0]  sq_res, sq_cand;
  logic [4:0]   sq_cnt;
  logic         sq_busy;
  logic [30:0]  len;

  always_comb begin
    sq_state_next = sq_state;
    case (sq_state)
      SQ_LOAD: sq_state_next = SQ_RUN;
      SQ_RUN:  if (sq_cnt == 5'd0) sq_state_next = SQ_IDLE;
      SQ_IDLE: sq_state_next = SQ_IDLE;
      default: sq_state_next = SQ_LOAD;
    endcase
    if (dir_wr) sq_state_next = SQ_LOAD;
  end

  always_comb begin
    sq_busy = (sq_state != SQ_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_state <= SQ_LOAD;
    end else begin
      sq_state <= sq_state_next;
    end
  end

  assign sq_cand = sq_res | (32'd1 << sq_cnt);

  always_ff @(posedge clk) begin
    case (sq_state)
      SQ_LOAD: begin
        sq_a   <= $unsigned(mul(axis_dir_x, axis_dir_x))
                + $unsigned(mul(axis_dir_y, axis_dir_y));
        sq_res <= '0;
        sq_cnt <= 5'd31;
      end
      SQ_RUN: begin
        if ((64'(sq_cand) * 64'(sq_cand)) <= sq_a) sq_res <= sq_cand;
        sq_cnt <= sq_cnt - 5'd1;
      end
      default: sq_cnt <= sq_cnt;
    endcase
  end

  assign len = sq_res[31] ? 31'h7FFF_FFFF : sq_res[30:0];

  // global advance: the pipe moves unless a result waits and is not taken
  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce && !sq_busy;

  pipe_t s1, s2, s3, s4, s5, s6, s7, s8, s9, s10, s11, s12, s13, s14;
  logic  v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15;
  pipe_t dl1 [0:DIV_LAT-1];
  pipe_t dl2 [0:DIV_LAT-1];
  pipe_t dl3 [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] dv1, dv2, dv3;

  logic signed [W-1:0] q_r, q_vr, q_vz, q_fm, q_rm, q_zm, q_fe, q_fx, q_fy;
  div_in_t             di_r, di_vr, di_vz, di_fm, di_rm, di_zm, di_fe, di_fx, di_fy;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15} <= '0;
      dv1 <= '0;
      dv2 <= '0;
      dv3 <= '0;
    end else if (ce) begin
      v1  <= s_axis_tvalid && s_axis_tready;
      v2  <= v1;
      v3  <= v2;
      dv1 <= {dv1[DIV_LAT-2:0], v3};
      v4  <= dv1[DIV_LAT-1];
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      dv2 <= {dv2[DIV_LAT-2:0], v11};
      v12 <= dv2[DIV_LAT-1];
      v13 <= v12;
      dv3 <= {dv3[DIV_LAT-2:0], v13};
      v14 <= dv3[DIV_LAT-1];
      v15 <= v14;
    end
  end

  // stage 1: unpack, offset from axis origin
  always_ff @(posedge clk) begin
    if (ce) begin
      s1     <= '0;
      s1.tag <= s_axis_tdata[31:0];
      s1.d   <= s_axis_tdata[63:32];
      s1.vx  <= s_axis_tdata[95:64];
      s1.vy  <= s_axis_tdata[127:96];
      s1.p   <= s_axis_tdata[159:128];
      s1.e   <= s_axis_tdata[191:160];
      s1.vol <= s_axis_tdata[287:256];
      s1.t   <= s_axis_tdata[319:288];
      s1.rx  <= sat32(SAT_W'($signed(s_axis_tdata[223:192])) - SAT_W'(axis_origin_x));
      s1.ry  <= sat32(SAT_W'($signed(s_axis_tdata[255:224])) - SAT_W'(axis_origin_y));
    end
  end

  // stage 2: cross and dot products with the axis
  always_ff @(posedge clk) begin
    if (ce) begin
      s2    <= s1;
      s2.pa <= mul(s1.rx, axis_dir_y);
      s2.pb <= mul(s1.ry, axis_dir_x);
      s2.pc <= mul(s1.vx, axis_dir_y);
      s2.pd <= mul(s1.vy, axis_dir_x);
      s2.pe <= mul(s1.vx, axis_dir_x);
      s2.pf <= mul(s1.vy, axis_dir_y);
    end
  end

  // stage 3: exact sums, split into sign and magnitude (the cross product keeps only its magnitude)
  logic signed [SAT_W-1:0] sum_cr, sum_vr, sum_vz;
  assign sum_cr = SAT_W'(s2.pa) - SAT_W'(s2.pb);
  assign sum_vr = SAT_W'(s2.pc) - SAT_W'(s2.pd);
  assign sum_vz = SAT_W'(s2.pe) + SAT_W'(s2.pf);

  always_ff @(posedge clk) begin
    if (ce) begin
      s3    <= s2;
      s3.ma <= sum_cr[SAT_W-1] ? 64'(-sum_cr) : 64'(sum_cr);
      s3.na <= 1'b0;
      s3.mb <= sum_vr[SAT_W-1] ? 64'(-sum_vr) : 64'(sum_vr);
      s3.nb <= sum_vr[SAT_W-1];
      s3.mc <= sum_vz[SAT_W-1] ? 64'(-sum_vz) : 64'(sum_vz);
      s3.nc <= sum_vz[SAT_W-1];
    end
  end

  // radius and velocities over the axis length
  assign di_r  = '{num_mag: s3.ma, num_neg: s3.na, den: len};
  assign di_vr = '{num_mag: s3.mb, num_neg: s3.nb, den: len};
  assign di_vz = '{num_mag: s3.mc, num_neg: s3.nc, den: len};

  cht_div u_div_r  (.clk(clk), .ce(ce), .din(di_r),  .quo(q_r));
  cht_div u_div_vr (.clk(clk), .ce(ce), .din(di_vr), .quo(q_vr));
  cht_div u_div_vz (.clk(clk), .ce(ce), .din(di_vz), .quo(q_vz));

  always_ff @(posedge clk) begin
    if (ce) begin
      dl1[0] <= s3;
      for (int i = 1; i < DIV_LAT; i++) dl1[i] <= dl1[i-1];
    end
  end

  // stage 4: capture quotients, density flux and kinetic products
  always_ff @(posedge clk) begin
    if (ce) begin
      s4         <= dl1[DIV_LAT-1];
      s4.r       <= q_r;
      s4.vr      <= q_vr;
      s4.vz      <= q_vz;
      s4.on_axis <= (q_r == '0);
      s4.pa      <= mul(dl1[DIV_LAT-1].d, q_vr);
      s4.pb      <= mul(q_vr, q_vr);
      s4.pc      <= mul(q_vz, q_vz);
    end
  end

  // stage 5: d*vr and half the squared speed
  always_ff @(posedge clk) begin
    if (ce) begin
      s5    <= s4;
      s5.dv <= qsh(s4.pa);
      s5.ke <= sat32((SAT_W'(s4.pb) + SAT_W'(s4.pc)) >>> (FRAC_BITS + 1));
    end
  end

  // stage 6: specific enthalpy term, momentum flux products
  always_ff @(posedge clk) begin
    if (ce) begin
      s6    <= s5;
      s6.h  <= sat32(SAT_W'(s5.e) + SAT_W'(s5.ke));
      s6.pa <= mul(s5.dv, s5.vr);
      s6.pb <= mul(s5.dv, s5.vz);
    end
  end

  // stage 7
  always_ff @(posedge clk) begin
    if (ce) begin
      s7     <= s6;
      s7.rmn <= qsh(s6.pa);
      s7.zmn <= qsh(s6.pb);
      s7.pc  <= mul(s6.d, s6.h);
    end
  end

  // stage 8
  always_ff @(posedge clk) begin
    if (ce) begin
      s8    <= s7;
      s8.dh <= qsh(s7.pc);
    end
  end

  // stage 9: pressure plus d*h
  always_ff @(posedge clk) begin
    if (ce) begin
      s9   <= s8;
      s9.q <= sat32(SAT_W'(s8.p) + SAT_W'(s8.dh));
    end
  end

  // stage 10
  always_ff @(posedge clk) begin
    if (ce) begin
      s10    <= s9;
      s10.pa <= mul(s9.vr, s9.q);
    end
  end

  // stage 11
  always_ff @(posedge clk) begin
    if (ce) begin
      s11    <= s10;
      s11.vq <= qsh(s10.pa);
    end
  end

  // flux terms over the radius
  assign di_fm = '{num_mag: {16'd0, abs32(s11.dv),  16'd0}, num_neg: s11.dv[W-1],  den: s11.r[30:0]};
  assign di_rm = '{num_mag: {16'd0, abs32(s11.rmn), 16'd0}, num_neg: s11.rmn[W-1], den: s11.r[30:0]};
  assign di_zm = '{num_mag: {16'd0, abs32(s11.zmn), 16'd0}, num_neg: s11.zmn[W-1], den: s11.r[30:0]};
  assign di_fe = '{num_mag: {16'd0, abs32(s11.vq),  16'd0}, num_neg: s11.vq[W-1],  den: s11.r[30:0]};

  cht_div u_div_fm (.clk(clk), .ce(ce), .din(di_fm), .quo(q_fm));
  cht_div u_div_rm (.clk(clk), .ce(ce), .din(di_rm), .quo(q_rm));
  cht_div u_div_zm (.clk(clk), .ce(ce), .din(di_zm), .quo(q_zm));
  cht_div u_div_fe (.clk(clk), .ce(ce), .din(di_fe), .quo(q_fe));

  always_ff @(posedge clk) begin
    if (ce) begin
      dl2[0] <= s11;
      for (int i = 1; i < DIV_LAT; i++) dl2[i] <= dl2[i-1];
    end
  end

  // stage 12: momentum projection and tracer products
  always_ff @(posedge clk) begin
    if (ce) begin
      s12    <= dl2[DIV_LAT-1];
      s12.fm <= q_fm;
      s12.rm <= q_rm;
      s12.zm <= q_zm;
      s12.fe <= q_fe;
      s12.pa <= mul(q_rm, axis_dir_y);
      s12.pb <= mul(q_zm, axis_dir_x);
      s12.pc <= mul(q_zm, axis_dir_y);
      s12.pd <= mul(q_rm, axis_dir_x);
      s12.pe <= mul(q_fm, dl2[DIV_LAT-1].t);
    end
  end

  // stage 13
  logic signed [SAT_W-1:0] sum_fx, sum_fy;
  assign sum_fx = SAT_W'(s12.pa) + SAT_W'(s12.pb);
  assign sum_fy = SAT_W'(s12.pc) - SAT_W'(s12.pd);

  always_ff @(posedge clk) begin
    if (ce) begin
      s13    <= s12;
      s13.ma <= sum_fx[SAT_W-1] ? 64'(-sum_fx) : 64'(sum_fx);
      s13.na <= sum_fx[SAT_W-1];
      s13.mb <= sum_fy[SAT_W-1] ? 64'(-sum_fy) : 64'(sum_fy);
      s13.nb <= sum_fy[SAT_W-1];
      s13.ft <= qsh(s12.pe);
    end
  end

  // momentum components over the axis length
  assign di_fx = '{num_mag: s13.ma, num_neg: s13.na, den: len};
  assign di_fy = '{num_mag: s13.mb, num_neg: s13.nb, den: len};

  cht_div u_div_fx (.clk(clk), .ce(ce), .din(di_fx), .quo(q_fx));
  cht_div u_div_fy (.clk(clk), .ce(ce), .din(di_fy), .quo(q_fy));

  always_ff @(posedge clk) begin
    if (ce) begin
      dl3[0] <= s13;
      for (int i = 1; i < DIV_LAT; i++) dl3[i] <= dl3[i-1];
    end
  end

  // stage 14: volume scaling products
  always_ff @(posedge clk) begin
    if (ce) begin
      s14    <= dl3[DIV_LAT-1];
      s14.fx <= q_fx;
      s14.fy <= q_fy;
      s14.pa <= mul(dl3[DIV_LAT-1].vol, dl3[DIV_LAT-1].fm);
      s14.pb <= mul(dl3[DIV_LAT-1].vol, q_fx);
      s14.pc <= mul(dl3[DIV_LAT-1].vol, q_fy);
      s14.pd <= mul(dl3[DIV_LAT-1].vol, dl3[DIV_LAT-1].fe);
      s14.pe <= mul(dl3[DIV_LAT-1].vol, dl3[DIV_LAT-1].ft);
    end
  end

  // stage 15: negate, shift, saturate, zero for cells on the axis; output register
  logic signed [W-1:0] o_mass, o_mx, o_my, o_en, o_tr;
  logic [W-1:0]        o_tag;
  logic                o_axis;

  always_ff @(posedge clk) begin
    if (ce) begin
      o_tag  <= s14.tag;
      o_axis <= s14.on_axis;
      o_mass <= s14.on_axis ? '0 : sat32((-SAT_W'(s14.pa)) >>> FRAC_BITS);
      o_mx   <= s14.on_axis ? '0 : sat32((-SAT_W'(s14.pb)) >>> FRAC_BITS);
      o_my   <= s14.on_axis ? '0 : sat32((-SAT_W'(s14.pc)) >>> FRAC_BITS);
      o_en   <= s14.on_axis ? '0 : sat32((-SAT_W'(s14.pd)) >>> FRAC_BITS);
      o_tr   <= s14.on_axis ? '0 : sat32((-SAT_W'(s14.pe)) >>> FRAC_BITS);
    end
  end

  assign m_axis_tvalid = v15;
  assign m_axis_tdata  = {o_tr, o_en, o_my, o_mx, o_mass, o_tag};
  assign m_axis_tuser  = o_axis;

  // checks
  a_no_item_while_sqrt: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> (sq_state == SQ_IDLE))
    else $error("item taken while axis length is being formed");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((sq_state == SQ_IDLE) && ((axis_dir_x != '0) || (axis_dir_y != '0))) |-> (len != '0))
    else $error("axis length zero for a nonzero direction");

  a_on_axis_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[191:32] == '0))
    else $error("source terms not zero for an item on the axis");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylindrical source term testbench
// Streams hydro cells through the block under several axis settings, with
// random idle bursts on both sides, and checks every result against a
// bit-exact fixed-point predictor of the cylindrical source terms.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [31:0]  q_t;

  typedef struct packed {
    q_t         tracer;
    q_t         volume;
    q_t         cy;
    q_t         cx;
    q_t         energy;
    q_t         pres;
    q_t         vy;
    q_t         vx;
    q_t         dens;
    logic [31:0] tag;
  } cell_t;

  typedef struct packed {
    logic       on_axis;
    q_t         tracer_src;
    q_t         energy_src;
    q_t         mom_y;
    q_t         mom_x;
    q_t         mass_src;
    logic [31:0] tag;
  } source_t;

  localparam int  LIMIT   = 600000;
  localparam int  DRAIN   = 160;
  localparam wide_t W_MAX = 128'sd2147483647;
  localparam wide_t W_MIN = -128'sd2147483648;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  q_t      axis_reg [4];
  source_t pending_sources [$];
  int      fail_count;
  int      cycle_count;
  bit      quiet;
  int      stall_left;

  cylindrical_hydro_source_term u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic q_t clamp_word(input wide_t v);
    if (v > W_MAX) return q_t'(W_MAX);
    if (v < W_MIN) return q_t'(W_MIN);
    return q_t'(v);
  endfunction

  // quotient toward zero, saturated; zero divisor gives zero
  function automatic q_t div_trunc(input wide_t num, input wide_t den);
    logic [127:0] mag;
    logic [127:0] quo;
    if (den == 0) return '0;
    mag = (num < 0) ? -num : num;
    quo = mag / den;
    if (num < 0) return (quo > 128'd2147483648) ? q_t'(W_MIN) : q_t'(-quo);
    return (quo >= 128'd2147483648) ? q_t'(W_MAX) : q_t'(quo);
  endfunction

  function automatic wide_t floor_sqrt(input wide_t a);
    logic [63:0]  res;
    logic [63:0]  cand;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= 128'(a)) res = cand;
    end
    return wide_t'({64'd0, res});
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return clamp_word(p >>> 16);
  endfunction

  function automatic q_t fx_div(input q_t a, input q_t b);
    wide_t n;
    if (b == 0) return '0;
    n = wide_t'(a) * 128'sd65536;
    if (b < 0) n = -n;
    return div_trunc(n, (b < 0) ? -wide_t'(b) : wide_t'(b));
  endfunction

  function automatic q_t vol_scaled(input q_t vol, input q_t f);
    wide_t p;
    p = -(wide_t'(vol) * wide_t'(f));
    return clamp_word(p >>> 16);
  endfunction

  function automatic source_t cylinder_sources(input cell_t c);
    source_t s;
    wide_t ox, oy, dx, dy, len, rx, ry, cr;
    q_t r, vr, vz, dv, fm, rm, zm, fx, fy, ke, h, qq, fe, ft;
    ox = axis_reg[0]; oy = axis_reg[1]; dx = axis_reg[2]; dy = axis_reg[3];
    s = '0;
    s.tag = c.tag;
    len = floor_sqrt(dx * dx + dy * dy);
    if (len > W_MAX) len = W_MAX;
    rx = clamp_word(wide_t'(c.cx) - ox);
    ry = clamp_word(wide_t'(c.cy) - oy);
    cr = rx * dy - ry * dx;
    if (cr < 0) cr = -cr;
    r = div_trunc(cr, len);
    if (r == 0) begin
      s.on_axis = 1'b1;
      return s;
    end
    vr = div_trunc(wide_t'(c.vx) * dy - wide_t'(c.vy) * dx, len);
    vz = div_trunc(wide_t'(c.vx) * dx + wide_t'(c.vy) * dy, len);
    dv = fx_mul(c.dens, vr);
    fm = fx_div(dv, r);
    rm = fx_div(fx_mul(dv, vr), r);
    zm = fx_div(fx_mul(dv, vz), r);
    fx = div_trunc(wide_t'(rm) * dy + wide_t'(zm) * dx, len);
    fy = div_trunc(wide_t'(zm) * dy - wide_t'(rm) * dx, len);
    // half the squared speed: one more bit of shift
    ke = clamp_word((wide_t'(vr) * wide_t'(vr) + wide_t'(vz) * wide_t'(vz)) >>> 17);
    h  = clamp_word(wide_t'(c.energy) + wide_t'(ke));
    qq = clamp_word(wide_t'(c.pres) + wide_t'(fx_mul(c.dens, h)));
    fe = fx_div(fx_mul(vr, qq), r);
    ft = fx_mul(fm, c.tracer);
    s.mass_src   = vol_scaled(c.volume, fm);
    s.mom_x      = vol_scaled(c.volume, fx);
    s.mom_y      = vol_scaled(c.volume, fy);
    s.energy_src = vol_scaled(c.volume, fe);
    s.tracer_src = vol_scaled(c.volume, ft);
    return s;
  endfunction

  // ---------------- monitors ----------------

  // predict on each accepted cell
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      pending_sources.push_back(cylinder_sources(cell_t'(s_axis_tdata)));
  end

  // result side stall bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    source_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (pending_sources.size() == 0) begin
        $error("unexpected result item, tag %h", got.tag);
        fail_count++;
      end else begin
        want = pending_sources.pop_front();
        if (got.tag !== want.tag) begin
          $error("tag_out: expected %h, got %h", want.tag, got.tag); fail_count++;
        end
        if (got.mass_src !== want.mass_src) begin
          $error("mass_src: expected %h, got %h", want.mass_src, got.mass_src);
          fail_count++;
        end
        if (got.mom_x !== want.mom_x) begin
          $error("mom_src_x: expected %h, got %h", want.mom_x, got.mom_x); fail_count++;
        end
        if (got.mom_y !== want.mom_y) begin
          $error("mom_src_y: expected %h, got %h", want.mom_y, got.mom_y); fail_count++;
        end
        if (got.energy_src !== want.energy_src) begin
          $error("energy_src: expected %h, got %h", want.energy_src, got.energy_src);
          fail_count++;
        end
        if (got.tracer_src !== want.tracer_src) begin
          $error("tracer_src: expected %h, got %h", want.tracer_src, got.tracer_src);
          fail_count++;
        end
        if (got.on_axis !== want.on_axis) begin
          $error("on_axis: expected %b, got %b", want.on_axis, got.on_axis); fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- shared tasks ----------------

  task automatic send_cell(input cell_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait for every expected result, then let the pipe settle
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sources.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_axis(input logic [1:0] idx, input q_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    axis_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic q_t rand_q();
    case ($urandom_range(0, 3))
      0:       return q_t'($urandom);
      1:       return q_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      2:       return q_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return q_t'($urandom_range(0, 1023)) - 32'sd512;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.tag = $urandom;
    c.dens = rand_q(); c.vx = rand_q(); c.vy = rand_q();
    c.pres = rand_q(); c.energy = rand_q();
    c.cx = rand_q(); c.cy = rand_q();
    c.volume = rand_q(); c.tracer = rand_q();
    // some cells sit right on the axis
    if ($urandom_range(0, 19) == 0) begin
      c.cx = axis_reg[0];
      c.cy = axis_reg[1];
    end
    return c;
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed();
    cell_t c;
    q_t    vals [4];
    vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 32'sh0000_0000};
    // every field at each value in turn: both extremes, one and zero
    foreach (vals[i]) begin
      c = {10{vals[i]}};
      send_cell(c);
    end
    // cell on the axis
    c = rand_cell();
    c.cx = axis_reg[0]; c.cy = axis_reg[1];
    send_cell(c);
    // simple unit cell off the axis, then mixed signs
    c = '{tracer: 32'sh0002_0000, volume: 32'sh0001_0000, cy: 32'sh0000_8000,
          cx: 32'sh0003_0000, energy: 32'sh0001_0000, pres: 32'sh0001_0000,
          vy: 32'sh0000_4000, vx: 32'sh0001_0000, dens: 32'sh0001_0000,
          tag: 32'hFFFF_FFFF};
    send_cell(c);
    c.vx = -c.vx; c.cx = -c.cx; c.volume = 32'sh7FFF_FFFF;
    send_cell(c);
    c.dens = 32'sh8000_0000; c.tag = 32'h0;
    send_cell(c);
    repeat (12) send_cell(rand_cell());
  endtask

  task automatic test_random_cells(input int count);
    repeat (count) send_cell(rand_cell());
  endtask

  task automatic test_axis_setting(input q_t ox, input q_t oy, input q_t dx,
                                   input q_t dy, input int count);
    drain_pipe();
    write_axis(cht_pkg::REG_ORIGIN_X, ox);
    write_axis(cht_pkg::REG_ORIGIN_Y, oy);
    write_axis(cht_pkg::REG_DIR_X, dx);
    write_axis(cht_pkg::REG_DIR_Y, dy);
    @(posedge clk);
    test_random_cells(count);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    quiet = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    stall_left = 0;
    axis_reg = '{32'sd0, 32'sd0, 32'sd0, cht_pkg::DIR_Y_RESET};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_cells(150);
    test_axis_setting(32'sh0001_8000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0000_0000, 120);
    test_axis_setting(q_t'($urandom), q_t'($urandom), 32'sh0000_C000, -32'sh0001_4000, 120);
    // no axis direction: every cell counts as on the axis
    test_axis_setting(32'sd0, 32'sd0, 32'sd0, 32'sd0, 30);
    test_axis_setting(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 100);
    test_axis_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 60);
    test_axis_setting(rand_q(), rand_q(), 32'sh0000_0001, 32'sh0000_0001, 60);
    test_axis_setting(rand_q(), rand_q(), rand_q(), rand_q(), 90);
    // last part runs back to back with no idling
    drain_pipe();
    quiet = 1'b1;
    test_random_cells(100);
    drain_pipe();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: cylindrical_hydro_source_term.f
rtl/cht_pkg.sv
rtl/cht_div.sv
rtl/cylindrical_hydro_source_term.sv
tb/testbench.sv
